// ----- src/vlpd_pkg.sv -----
`timescale 1ns / 1ps

package vlpd_pkg;

  localparam int unsigned LenW  = 29;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;

  localparam logic [LenW-1:0] MaxLenReset = LenW'(32'd16777216);
  localparam logic [CntW-1:0] PrefixMax   = CntW'(3'd4);

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALTED  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             end_of_message;
    logic             length_error;
  } res_t;

endpackage

// ----- src/vlpd_core.sv -----
`timescale 1ns / 1ps

module vlpd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [vlpd_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        cfg_we_i,
  input  logic [vlpd_pkg::LenW-1:0]   cfg_data_i,
  output logic                        emit_o,
  output vlpd_pkg::res_t              res_o
);

  vlpd_pkg::phase_e                phase_q, phase_d;
  logic [vlpd_pkg::CntW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [vlpd_pkg::LenW-1:0]       accum_q, accum_d, accum_add, term;
  logic [vlpd_pkg::LenW-1:0]       left_q, left_d, left_dec;
  logic [vlpd_pkg::LenW-1:0]       max_len_q;
  logic                            done, bad, last;

  always_comb begin
    cnt_inc   = cnt_q + vlpd_pkg::CntW'(1);
    case (cnt_inc)
      3'd1:    term = vlpd_pkg::LenW'(in_byte_i[6:0]);
      3'd2:    term = vlpd_pkg::LenW'({in_byte_i[6:0], 7'd0});
      3'd3:    term = vlpd_pkg::LenW'({in_byte_i[6:0], 14'd0});
      default: term = {in_byte_i, 21'd0};
    endcase
    accum_add = accum_q + term;
    done      = !in_byte_i[7] || (cnt_inc >= vlpd_pkg::PrefixMax);
    bad       = (accum_add == '0) || (accum_add > max_len_q);
    left_dec  = left_q - vlpd_pkg::LenW'(1);
    last      = (left_dec == '0);

    phase_d = phase_q;
    cnt_d   = cnt_q;
    accum_d = accum_q;
    left_d  = left_q;
    emit_o  = 1'b0;
    res_o   = '0;

    if (accept_i) begin
      unique case (phase_q)
        vlpd_pkg::PH_PREFIX: begin
          cnt_d   = cnt_inc;
          accum_d = accum_add;
          if (done) begin
            if (bad) begin
              phase_d            = vlpd_pkg::PH_HALTED;
              emit_o             = 1'b1;
              res_o.length_error = 1'b1;
            end else begin
              left_d  = accum_add;
              phase_d = vlpd_pkg::PH_PAYLOAD;
            end
          end
        end
        vlpd_pkg::PH_PAYLOAD: begin
          left_d               = left_dec;
          emit_o               = 1'b1;
          res_o.out_byte       = in_byte_i;
          res_o.end_of_message = last;
          if (last) begin
            phase_d = vlpd_pkg::PH_PREFIX;
            cnt_d   = '0;
            accum_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= vlpd_pkg::PH_PREFIX;
      cnt_q     <= '0;
      accum_q   <= '0;
      left_q    <= '0;
      max_len_q <= vlpd_pkg::MaxLenReset;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // halted swallows every beat
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == vlpd_pkg::PH_HALTED) |-> !emit_o)
    else $error("result emitted while halted");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && res_o.length_error) |=> (phase_q == vlpd_pkg::PH_HALTED))
    else $error("length error did not halt");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == vlpd_pkg::PH_PAYLOAD) |-> (left_q != '0))
    else $error("payload phase with no bytes left");

  a_prefix_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == vlpd_pkg::PH_PREFIX) |-> (cnt_q < vlpd_pkg::PrefixMax))
    else $error("prefix counter overran");

endmodule

// ----- src/vlpd_out_buf.sv -----
`timescale 1ns / 1ps

module vlpd_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vlpd_pkg::res_t  res_i,
  output logic            space_o,
  output logic            valid_o,
  input  logic            ready_i,
  output vlpd_pkg::res_t  res_o
);

  vlpd_pkg::res_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2))
    else $error("push into full output buffer");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("output buffer pointers inconsistent");

endmodule

// ----- src/varint_length_prefix_deframer.sv -----
`timescale 1ns / 1ps
// A payload or error beat is written into the output buffer as its input beat is accepted.
// Throughput: one input beat per cycle; a 2-entry output buffer keeps input ready while
// one result waits, so input stalls only when two results are held.
// Reset (async, active low): prefix phase, counters cleared, max_length = 16777216.
// After a length error all input is consumed silently until reset.
module varint_length_prefix_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [vlpd_pkg::ByteW-1:0]  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vlpd_pkg::ByteW-1:0]  out_byte_o,
  output logic                        end_of_message_o,
  output logic                        length_error_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [vlpd_pkg::LenW-1:0]   cfg_data_i
);

  logic           accept, emit, space;
  vlpd_pkg::res_t res, out_res;

  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;
  assign cfg_ready_o = 1'b1;

  vlpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .emit_o    (emit),
    .res_o     (res)
  );

  vlpd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .res_i  (res),
    .space_o(space),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (out_res)
  );

  assign out_byte_o       = out_res.out_byte;
  assign end_of_message_o = out_res.end_of_message;
  assign length_error_o   = out_res.length_error;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RandBytes  = 900;
  localparam int unsigned QuietPart  = 760;
  localparam int unsigned StallLimit = 2000;
  localparam logic [vlpd_pkg::LenW-1:0] LenAllOnes = '1;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [vlpd_pkg::ByteW-1:0] in_byte_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [vlpd_pkg::ByteW-1:0] out_byte_o;
  logic                       end_of_message_o;
  logic                       length_error_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [vlpd_pkg::LenW-1:0]  cfg_data_i;

  varint_length_prefix_deframer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .end_of_message_o (end_of_message_o),
    .length_error_o   (length_error_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // deframer state as the testbench sees it
  vlpd_pkg::phase_e          ph        = vlpd_pkg::PH_PREFIX;
  logic [vlpd_pkg::CntW-1:0] pfx_count = '0;
  logic [vlpd_pkg::LenW-1:0] len_acc   = '0;
  logic [vlpd_pkg::LenW-1:0] remaining = '0;
  logic [vlpd_pkg::LenW-1:0] max_len   = vlpd_pkg::MaxLenReset;
  vlpd_pkg::res_t            deframed_q[$];

  bit          gaps_on = 1'b1;
  int unsigned bytes_sent;
  int unsigned cur_max = 32'(vlpd_pkg::MaxLenReset);
  int unsigned mismatches;
  int unsigned payload_beats;
  int unsigned messages_done;
  int unsigned cfg_writes;
  int unsigned error_beats;
  int unsigned idle_cycles;

  function automatic void deframe_byte(input logic [vlpd_pkg::ByteW-1:0] b);
    vlpd_pkg::res_t r;
    case (ph)
      vlpd_pkg::PH_PREFIX: begin
        pfx_count = pfx_count + 1'b1;
        case (pfx_count)
          3'd1:    len_acc = len_acc + {22'd0, b[6:0]};
          3'd2:    len_acc = len_acc + ({22'd0, b[6:0]} << 7);
          3'd3:    len_acc = len_acc + ({22'd0, b[6:0]} << 14);
          default: len_acc = len_acc + ({21'd0, b} << 21);
        endcase
        if (!(b[7] && pfx_count < vlpd_pkg::PrefixMax)) begin
          if (len_acc == '0 || len_acc > max_len) begin
            ph = vlpd_pkg::PH_HALTED;
            r = '{out_byte: '0, end_of_message: 1'b0, length_error: 1'b1};
            deframed_q.push_back(r);
          end else begin
            remaining = len_acc;
            ph = vlpd_pkg::PH_PAYLOAD;
          end
        end
      end
      vlpd_pkg::PH_PAYLOAD: begin
        remaining = remaining - 1'b1;
        r = '{out_byte: b, end_of_message: (remaining == '0), length_error: 1'b0};
        deframed_q.push_back(r);
        if (remaining == '0) begin
          ph = vlpd_pkg::PH_PREFIX;
          pfx_count = '0;
          len_acc = '0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : watch_beats
    vlpd_pkg::res_t want;
    vlpd_pkg::res_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) max_len = cfg_data_i;
      if (in_valid_i && in_ready_o) deframe_byte(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        got = '{out_byte: out_byte_o, end_of_message: end_of_message_o,
                length_error: length_error_o};
        if (got.length_error) error_beats++;
        else payload_beats++;
        if (got.end_of_message) messages_done++;
        if (deframed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat: byte %02h eom %b err %b", $realtime,
                     got.out_byte, got.end_of_message, got.length_error);
        end else begin
          want = deframed_q.pop_front();
          if (got.out_byte !== want.out_byte || got.end_of_message !== want.end_of_message ||
              got.length_error !== want.length_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected byte %02h eom %b err %b, got %02h %b %b",
                       $realtime, want.out_byte, want.end_of_message, want.length_error,
                       got.out_byte, got.end_of_message, got.length_error);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output back-pressure
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 11) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [vlpd_pkg::ByteW-1:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // length must fit the prefix size: below 128 for one byte, 16384 for two
  task automatic send_message(input int unsigned len, input int unsigned nbytes);
    logic [vlpd_pkg::LenW-1:0] l;
    l = len[vlpd_pkg::LenW-1:0];
    for (int k = 0; k < nbytes; k++) begin
      if (k == 3) send_byte(l[28:21]);
      else send_byte({(k != nbytes - 1), l[7*k +: 7]});
    end
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_length(input int unsigned v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[vlpd_pkg::LenW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_max = v;
    cfg_writes++;
  endtask

  task automatic test_short_messages();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h5A);
    send_byte(8'hA5);
  endtask

  // padded prefixes: continuation bytes carrying zero groups
  task automatic test_prefix_forms();
    send_byte(8'h83);
    send_byte(8'h00);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h81);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h3C);
  endtask

  task automatic test_max_length_extremes();
    set_max_length(1);
    send_message(1, 1);
    set_max_length(32'(LenAllOnes));
    send_message(1, 4);
    set_max_length(3);
    send_message(3, 1);
  endtask

  task automatic test_random_stream();
    int unsigned len;
    int unsigned cap;
    int unsigned next_cfg;
    next_cfg = bytes_sent;
    while (bytes_sent < RandBytes) begin
      if (bytes_sent >= next_cfg) begin
        case ($urandom_range(0, 5))
          0:       set_max_length(1);
          1:       set_max_length($urandom_range(2, 12));
          2:       set_max_length($urandom_range(13, 400));
          3:       set_max_length(32'(LenAllOnes));
          4:       set_max_length(32'(vlpd_pkg::MaxLenReset));
          default: set_max_length($urandom_range(401, 32'(LenAllOnes)));
        endcase
        next_cfg = bytes_sent + $urandom_range(80, 200);
      end
      if (bytes_sent >= QuietPart) gaps_on = 1'b0;
      cap = (cur_max < 12) ? cur_max : 12;
      len = $urandom_range(1, cap);
      if (cur_max > 12 && $urandom_range(0, 24) == 0)
        len = $urandom_range(13, (cur_max < 300) ? cur_max : 300);
      send_message(len, $urandom_range((len >= 128) ? 2 : 1, 4));
    end
  endtask

  // ends the usable life of the block: it stays halted until reset
  task automatic test_length_error();
    int unsigned nb;
    if ($urandom_range(0, 1) == 0) begin
      nb = $urandom_range(1, 4);
      repeat (nb - 1) send_byte(8'h80);
      send_byte(8'h00);
    end else begin
      set_max_length($urandom_range(1, 29'h0FFF_FFFF));
      repeat (4) send_byte(8'($urandom_range(128, 255)));
    end
    repeat (5) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_messages();
    test_prefix_forms();
    test_max_length_extremes();
    test_random_stream();
    test_length_error();
    settle();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d messages, %0d payload beats, %0d length errors, %0d input bytes,",
             messages_done, payload_beats, error_beats, bytes_sent);
    $display("and %0d max_length writes including both extremes; %0d mismatches.",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
